// ----- hdl/hs1d_pkg.sv -----
// hs1d_pkg: sequencer states, register indexes and the three-point stencil
// used by the explicit heat stencil block.
// No dependencies.
package hs1d_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BOUND,
		ST_SWEEP,
		ST_FLUSH,
		ST_OUT
	} state_t;

	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_LEFT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEPS = 2'd2;

	localparam int unsigned TEMP_W  = 32;
	localparam int unsigned STEPS_W = 20;

	// floor((l + 2c + r) / 4); dropping the two low bits of the signed sum is the floor
	function automatic logic [TEMP_W-1:0] stencil(
		input logic [TEMP_W-1:0] l,
		input logic [TEMP_W-1:0] c,
		input logic [TEMP_W-1:0] r
	);
		logic [TEMP_W+1:0] sum;
		sum = {{2{l[TEMP_W-1]}}, l} + {c[TEMP_W-1], c, 1'b0} + {{2{r[TEMP_W-1]}}, r};
		return sum[TEMP_W+1:2];
	endfunction

endpackage

// ----- hdl/explicit_heat_stencil_1d.sv -----
// explicit_heat_stencil_1d: 1-D explicit heat stencil over a CELLS-entry store,
// swept in place by one shared stencil adder under a small sequencer.
// Depends on hs1d_pkg.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  load     | load_valid / load_stall  | temperature
//  result   | result_valid/result_stall| cell_temperature, last_cell
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Loading takes one word per cycle; load_stall is high from the last cell on.
// During the run one store read port feeds the stencil adder one cell per cycle per step.
// Results leave one word per cycle unless result_stall holds them.
// Reset clears the sequencer and registers; the store itself is not cleared.
module explicit_heat_stencil_1d #(
	parameter int unsigned CELLS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load_valid,
	output logic                               load_stall,
	input  logic signed [hs1d_pkg::TEMP_W-1:0] temperature,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [hs1d_pkg::TEMP_W-1:0] cell_temperature,
	output logic                               last_cell,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [hs1d_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [hs1d_pkg::TEMP_W-1:0]        cfg_data
);

	localparam int unsigned IW = $clog2(CELLS);
	localparam logic [IW-1:0] LAST = IW'(CELLS - 1);

	hs1d_pkg::state_t state_q, state_nx;

	logic [hs1d_pkg::TEMP_W-1:0]  left_q, right_q;
	logic [hs1d_pkg::STEPS_W-1:0] step_count_q, steps_q;
	logic [IW-1:0]                load_q, addr_q, ra_q;
	logic                         rv_s1, ov_q;
	logic [hs1d_pkg::TEMP_W-1:0]  store [CELLS];
	logic [hs1d_pkg::TEMP_W-1:0]  mem_rd_q;
	logic [hs1d_pkg::TEMP_W-1:0]  win_l_q, win_c_q;

	logic                         load_fire, out_fire, last_step, last_taken;
	logic                         we, rd_en;
	logic [IW-1:0]                wa;
	logic [hs1d_pkg::TEMP_W-1:0]  wd;

	assign cfg_ready = 1'b1;
	assign load_fire = load_valid && !load_stall;
	assign out_fire  = result_valid && !result_stall;
	assign last_step = ({1'b0, steps_q} + 21'd1) == {1'b0, step_count_q};
	assign last_taken = out_fire && (ra_q == LAST);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			hs1d_pkg::ST_LOAD: begin
				if (load_fire && load_q == LAST) state_nx = hs1d_pkg::ST_BOUND;
			end
			hs1d_pkg::ST_BOUND: begin
				state_nx = (step_count_q == '0) ? hs1d_pkg::ST_OUT : hs1d_pkg::ST_SWEEP;
			end
			hs1d_pkg::ST_SWEEP: begin
				if (addr_q == LAST && last_step) state_nx = hs1d_pkg::ST_FLUSH;
			end
			hs1d_pkg::ST_FLUSH: begin
				state_nx = hs1d_pkg::ST_OUT;
			end
			hs1d_pkg::ST_OUT: begin
				if (last_taken) state_nx = hs1d_pkg::ST_LOAD;
			end
			default: begin
				state_nx = hs1d_pkg::ST_LOAD;
			end
		endcase
	end

	// outputs of the sequencer: load stall, store write port and read enable
	always_comb begin
		load_stall = 1'b1;
		we    = 1'b0;
		wa    = ra_q - IW'(1);
		wd    = hs1d_pkg::stencil(win_l_q, win_c_q, mem_rd_q);
		rd_en = 1'b0;
		case (state_q)
			hs1d_pkg::ST_LOAD: begin
				load_stall = 1'b0;
				we = load_fire;
				wa = load_q;
				// the right end cell takes the boundary instead of the loaded word
				wd = (load_q == LAST) ? right_q : temperature;
			end
			hs1d_pkg::ST_BOUND: begin
				we = 1'b1;
				wa = '0;
				wd = left_q;
			end
			hs1d_pkg::ST_SWEEP: begin
				rd_en = 1'b1;
				we = rv_s1 && (ra_q >= IW'(2));
			end
			hs1d_pkg::ST_FLUSH: begin
				we = rv_s1 && (ra_q >= IW'(2));
			end
			hs1d_pkg::ST_OUT: begin
				rd_en = (!ov_q || !result_stall) && !(ov_q && ra_q == LAST);
			end
			default: begin
				load_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= hs1d_pkg::ST_LOAD;
			left_q       <= '0;
			right_q      <= '0;
			step_count_q <= '0;
			load_q       <= '0;
			addr_q       <= '0;
			steps_q      <= '0;
			ra_q         <= '0;
			rv_s1        <= 1'b0;
			ov_q         <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					hs1d_pkg::REG_LEFT:  left_q <= cfg_data;
					hs1d_pkg::REG_RIGHT: right_q <= cfg_data;
					hs1d_pkg::REG_STEPS: step_count_q <= cfg_data[hs1d_pkg::STEPS_W-1:0];
					default: ;
				endcase
			end
			if (load_fire) load_q <= (load_q == LAST) ? '0 : load_q + IW'(1);
			if (state_q == hs1d_pkg::ST_BOUND) begin
				addr_q  <= '0;
				steps_q <= '0;
			end else if (state_q == hs1d_pkg::ST_FLUSH) begin
				addr_q <= '0;
			end else if (rd_en) begin
				addr_q <= (addr_q == LAST) ? '0 : addr_q + IW'(1);
				if (state_q == hs1d_pkg::ST_SWEEP && addr_q == LAST)
					steps_q <= steps_q + hs1d_pkg::STEPS_W'(1);
			end
			if (rd_en) ra_q <= addr_q;
			rv_s1 <= (state_q == hs1d_pkg::ST_SWEEP);
			if (state_q == hs1d_pkg::ST_OUT && rd_en) ov_q <= 1'b1;
			else if (!result_stall) ov_q <= 1'b0;
		end
	end

	// cell store: one write and one registered read per cycle; mem_rd_q is also the
	// result word register
	always_ff @(posedge clk) begin
		if (we) store[wa] <= wd;
		if (rd_en) mem_rd_q <= store[addr_q];
	end

	// sliding window holds the previous step's left and centre cells
	always_ff @(posedge clk) begin
		if (rv_s1) begin
			win_l_q <= win_c_q;
			win_c_q <= mem_rd_q;
		end
	end

	assign result_valid     = ov_q;
	assign cell_temperature = $signed(mem_rd_q);
	assign last_cell        = (ra_q == LAST);

	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> state_q == hs1d_pkg::ST_OUT)
		else $error("result word outside output phase");

	a_sweep_keeps_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == hs1d_pkg::ST_SWEEP || state_q == hs1d_pkg::ST_FLUSH) && we)
		|-> (wa != '0 && wa != LAST))
		else $error("sweep wrote a boundary cell");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && last_cell) |=> (!result_valid && state_q == hs1d_pkg::ST_LOAD))
		else $error("result after last cell");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != hs1d_pkg::ST_LOAD) |-> load_stall)
		else $error("load taken while busy");

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for explicit_heat_stencil_1d. It loads cell sets, predicts
// the stencil runs in-bench and checks every result word in order.
// Depends on hs1d_pkg and explicit_heat_stencil_1d.
module tb;

	localparam int unsigned CELLS = 64;
	localparam logic [hs1d_pkg::REG_IDX_W-1:0] REG_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	// longest silent stretch is the 4095-step run
	localparam int QUIET_LIMIT = 1000000;

	typedef struct packed {
		logic [hs1d_pkg::TEMP_W-1:0] temp;
		logic                        is_last;
	} cell_word_t;

	logic clk;
	logic arst_n = 1'b0;
	logic load_valid = 1'b0;
	logic load_stall;
	logic signed [hs1d_pkg::TEMP_W-1:0] temperature = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [hs1d_pkg::TEMP_W-1:0] cell_temperature;
	logic last_cell;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hs1d_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [hs1d_pkg::TEMP_W-1:0] cfg_data = '0;

	// shadow copy of the block
	logic [hs1d_pkg::TEMP_W-1:0]  left_temp = '0;
	logic [hs1d_pkg::TEMP_W-1:0]  right_temp = '0;
	logic [hs1d_pkg::STEPS_W-1:0] step_total = '0;
	logic [hs1d_pkg::TEMP_W-1:0]  heat_grid [CELLS];
	int cells_loaded = 0;
	cell_word_t expected_cells [$];

	int error_count = 0;
	int out_cell = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	bit load_up = 1'b0;
	bit cfg_up = 1'b0;

	explicit_heat_stencil_1d #(.CELLS(CELLS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.load_valid(load_valid),
		.load_stall(load_stall),
		.temperature(temperature),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cell_temperature(cell_temperature),
		.last_cell(last_cell),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic void log_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("tb: %s", msg);
	endfunction

	// floor((l + 2c + r) / 4) in 64-bit signed arithmetic
	function automatic logic [hs1d_pkg::TEMP_W-1:0] quarter_sum(
			input logic [hs1d_pkg::TEMP_W-1:0] l,
			input logic [hs1d_pkg::TEMP_W-1:0] c,
			input logic [hs1d_pkg::TEMP_W-1:0] r);
		longint s;
		s = longint'($signed(l)) + 2 * longint'($signed(c)) + longint'($signed(r));
		s = s >>> 2;
		return s[hs1d_pkg::TEMP_W-1:0];
	endfunction

	// store one cell; a full set runs the steps and queues all cells
	function automatic void track_temperature(input logic [hs1d_pkg::TEMP_W-1:0] v);
		logic [hs1d_pkg::TEMP_W-1:0] prev [CELLS];
		int s;
		int i;
		heat_grid[cells_loaded] = v;
		cells_loaded++;
		if (cells_loaded == CELLS) begin
			cells_loaded = 0;
			heat_grid[0] = left_temp;
			heat_grid[CELLS-1] = right_temp;
			for (s = 0; s < int'(step_total); s++) begin
				prev = heat_grid;
				for (i = 1; i < CELLS - 1; i++)
					heat_grid[i] = quarter_sum(prev[i-1], prev[i], prev[i+1]);
			end
			for (i = 0; i < CELLS; i++)
				expected_cells.push_back('{temp: heat_grid[i], is_last: (i == CELLS - 1)});
		end
	endfunction

	function automatic logic [hs1d_pkg::TEMP_W-1:0] random_temp();
		case ($urandom_range(3))
			0: return $urandom;
			1: return hs1d_pkg::TEMP_W'($signed($urandom_range(2000)) - 1000);
			2: return hs1d_pkg::TEMP_W'($signed($urandom_range(200 << 16)) - (100 << 16));
			default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
		endcase
	endfunction

	// valid stays up after acceptance so the next word can follow at once
	task automatic load_temperature(input logic [hs1d_pkg::TEMP_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			if (load_up) begin
				load_valid <= 1'b0;
				load_up = 1'b0;
			end
			@(posedge clk);
		end
		load_valid <= 1'b1;
		load_up = 1'b1;
		temperature <= v;
		do @(posedge clk); while (load_stall);
		track_temperature(v);
	endtask

	task automatic load_release();
		if (load_up) begin
			load_valid <= 1'b0;
			load_up = 1'b0;
		end
	endtask

	task automatic write_reg(input logic [hs1d_pkg::REG_IDX_W-1:0] idx,
			input logic [hs1d_pkg::TEMP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_up = 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			hs1d_pkg::REG_LEFT:  left_temp = data;
			hs1d_pkg::REG_RIGHT: right_temp = data;
			hs1d_pkg::REG_STEPS: step_total = data[hs1d_pkg::STEPS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic cfg_release();
		if (cfg_up) begin
			cfg_valid <= 1'b0;
			cfg_up = 1'b0;
		end
	endtask

	task automatic settle();
		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_random_set();
		int i;
		for (i = 0; i < CELLS; i++)
			load_temperature(random_temp());
		load_release();
	endtask

	// reset registers: zero boundaries and zero steps, so only the ends change
	task automatic test_reset_values();
		int i;
		logic [hs1d_pkg::TEMP_W-1:0] v;
		for (i = 0; i < CELLS; i++) begin
			case (i)
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				2: v = 32'h7fff_ffff;
				3: v = 32'h0000_0000;
				4: v = 32'hffff_ffff;
				5: v = 32'h0000_0001;
				CELLS - 1: v = 32'h8000_0000;
				default: v = random_temp();
			endcase
			load_temperature(v);
		end
		load_release();
		settle();
	endtask

	// full-scale words around a single step: floor of negative sums, no overflow
	task automatic test_one_step_extremes();
		int i;
		logic [hs1d_pkg::TEMP_W-1:0] v;
		write_reg(hs1d_pkg::REG_STEPS, 32'hffff_ffff);
		write_reg(hs1d_pkg::REG_LEFT, 32'h8000_0000);
		write_reg(hs1d_pkg::REG_RIGHT, 32'h7fff_ffff);
		write_reg(REG_NONE, 32'h5a5a_5a5a);
		// high data bits fall outside the step counter
		write_reg(hs1d_pkg::REG_STEPS, 32'hfff0_0001);
		cfg_release();
		for (i = 0; i < CELLS; i++) begin
			case (i % 10)
				0, 1, 2: v = 32'h7fff_ffff;
				3, 4, 5: v = 32'h8000_0000;
				6: v = 32'hffff_ffff;
				7: v = 32'h0000_0000;
				8: v = 32'h0000_0001;
				default: v = 32'hffff_fffe;
			endcase
			if (i >= 40)
				v = random_temp();
			load_temperature(v);
		end
		load_release();
		settle();
	endtask

	// registers rewritten halfway through a set apply to that set's run
	task automatic test_config_during_load();
		int i;
		write_reg(hs1d_pkg::REG_STEPS, 32'd3);
		write_reg(hs1d_pkg::REG_LEFT, $urandom);
		write_reg(hs1d_pkg::REG_RIGHT, $urandom);
		cfg_release();
		for (i = 0; i < 25; i++)
			load_temperature(random_temp());
		load_release();
		settle();
		write_reg(hs1d_pkg::REG_LEFT, 32'h0064_0000);
		write_reg(hs1d_pkg::REG_RIGHT, 32'hff9c_0000);
		write_reg(hs1d_pkg::REG_STEPS, 32'd5);
		cfg_release();
		for (i = 25; i < CELLS; i++)
			load_temperature(random_temp());
		load_release();
		settle();
	endtask

	task automatic test_long_run();
		write_reg(hs1d_pkg::REG_LEFT, 32'h7fff_ffff);
		write_reg(hs1d_pkg::REG_RIGHT, 32'h8000_0000);
		write_reg(hs1d_pkg::REG_STEPS, 32'd4095);
		cfg_release();
		load_random_set();
		settle();
	endtask

	// receiver: random stall, compare each accepted word with the oldest prediction
	always @(posedge clk) begin : result_check
		cell_word_t want;
		result_stall <= ($urandom_range(99) < stall_pct);
		if (result_valid && !result_stall) begin
			if (expected_cells.size() == 0) begin
				log_error($sformatf("unexpected word %h last=%b", cell_temperature, last_cell));
			end else begin
				want = expected_cells.pop_front();
				if (cell_temperature !== want.temp)
					log_error($sformatf("cell %0d temperature: expected %h, got %h",
						out_cell, want.temp, cell_temperature));
				if (last_cell !== want.is_last)
					log_error($sformatf("cell %0d last_cell: expected %b, got %b",
						out_cell, want.is_last, last_cell));
				out_cell = want.is_last ? 0 : out_cell + 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((load_valid && !load_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// no idling
		idle_pct = 0;
		stall_pct = 0;
		test_reset_values();
		// sender idle most of the time
		idle_pct = 74;
		stall_pct = 0;
		test_one_step_extremes();
		// receiver stalling most of the time
		idle_pct = 0;
		stall_pct = 74;
		test_config_during_load();
		// both sides idle now and then
		idle_pct = 24;
		stall_pct = 24;
		test_long_run();
		idle_pct = 0;
		stall_pct = 0;
		settle();
		if (error_count == 0 && expected_cells.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule
